@@ rtl/path_normalizer_core_assert.svh @@
// Assertion macros shared by the path normalizer RTL.
// Each macro expects clk and rst_n in scope and ends its own statement.
`ifndef PATH_NORMALIZER_CORE_ASSERT_SVH
`define PATH_NORMALIZER_CORE_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define PN_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define PN_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define PN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pn_pkg.sv @@
// ----------------------------------------------------------------------------
// pn_pkg
// Constants and codes shared by the path normalizer, its channels and its core.
// ----------------------------------------------------------------------------
package pn_pkg;

    localparam int PATH_MAX = 256;
    localparam int NAME_MAX = 64;
    localparam int COMP_MAX = 32;

    localparam int CH_W    = 8;
    localparam int LEN_W   = 8;
    localparam int ADDR_W  = $clog2(PATH_MAX);
    localparam int POS_W   = ADDR_W + 1;
    localparam int PB_W    = $clog2(PATH_MAX + 1);
    localparam int CLEN_W  = $clog2(NAME_MAX);
    localparam int STK_AW  = $clog2(COMP_MAX);
    localparam int DEPTH_W = $clog2(COMP_MAX + 1);
    localparam int CNT_W   = $clog2(COMP_MAX + 2);

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;

    localparam logic MODE_FEED = 1'b0;
    localparam logic MODE_READ = 1'b1;
    localparam logic PART_BASE = 1'b0;
    localparam logic PART_REQ  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_BASE_REL = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    localparam logic [1:0] PE_NONE  = 2'd0;
    localparam logic [1:0] PE_EMPTY = 2'd1;
    localparam logic [1:0] PE_LONG  = 2'd3;

    localparam logic [1:0] DP_NONE  = 2'd0;
    localparam logic [1:0] DP_ONE   = 2'd1;
    localparam logic [1:0] DP_TWO   = 2'd2;
    localparam logic [1:0] DP_OTHER = 2'd3;

endpackage

@@ rtl/pn_ifs.sv @@
// ----------------------------------------------------------------------------
// pn_ifs
// Valid/ready channels of the path normalizer: command items and result items.
// ----------------------------------------------------------------------------
interface pn_cmd_if import pn_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              mode;
    logic              part;
    logic [CH_W-1:0]   ch;
    logic [ADDR_W-1:0] index;

    modport source (output valid, output mode, output part, output ch, output index,
                    input ready);
    modport sink (input valid, input mode, input part, input ch, input index,
                  output ready);

endinterface

interface pn_res_if import pn_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [LEN_W-1:0] length;
    logic [LEN_W-1:0] leaf_start;
    logic [CH_W-1:0]  byte_out;

    modport source (output valid, output status, output length, output leaf_start,
                    output byte_out, input ready);
    modport sink (input valid, input status, input length, input leaf_start,
                  input byte_out, output ready);

endinterface

@@ rtl/path_normalizer_core.sv @@
// ----------------------------------------------------------------------------
// path_normalizer_core
// Canonical absolute path builder with a byte store and a component stack.
// ----------------------------------------------------------------------------
// The cmd channel carries one item per path byte (mode feed) or per store
// read (mode read). A base path and then a request path arrive as zero
// terminated byte runs; the request terminator and every read item each give
// one item on the res channel. Other items give none.
// Every accepted item updates the path state in the cycle it is accepted, so
// the block takes one item per clock as long as res is drained. A result
// passes the result stage, which holds the synchronous read of the 256 x 8
// byte store, and then the output register. The store has one write port and
// one read port, and at most one byte is written per item, which sets the
// one item per cycle rate.
// The component stack memory is read every cycle at the entry below the new
// top, so a parent reference pops with the new top already registered.
// When res stalls, a result stage and the output register hold two results;
// cmd.ready falls only while both are full and res.ready is low.
// After reset the path is the root "/", length 1, leaf offset 1. The store
// needs no clearing pass: byte zero is never written and always reads back as
// the slash; every other byte below the length is written before it is read.
// ----------------------------------------------------------------------------
`include "path_normalizer_core_assert.svh"

module path_normalizer_core import pn_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    pn_cmd_if.sink   cmd,
    pn_res_if.source res
);

    logic [CH_W-1:0]    store_mem [PATH_MAX];
    logic [LEN_W-1:0]   stk_mem [COMP_MAX];

    logic [LEN_W-1:0]   len_reg, len_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [LEN_W-1:0]   top_reg, top_next;
    logic [LEN_W-1:0]   below_reg;
    logic [CLEN_W-1:0]  clen_reg, clen_next;
    logic [1:0]         dots_reg, dots_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PB_W-1:0]    pbytes_reg, pbytes_next;
    logic               nerr_reg, nerr_next;
    logic [1:0]         perr_reg, perr_next;
    logic               bbad_reg, bbad_next;
    logic               start_reg, start_next;
    logic               inreq_reg, inreq_next;

    logic               s1_valid_reg, s1_valid_next;
    logic               o_valid_reg, o_valid_next;
    logic [1:0]         s1_status_reg;
    logic [LEN_W-1:0]   s1_len_reg;
    logic [LEN_W-1:0]   s1_leaf_reg;
    logic               s1_read_reg;
    logic               s1_root_reg;
    logic               s1_hit_reg;
    logic [CH_W-1:0]    rd_data_reg;
    logic [1:0]         o_status_reg;
    logic [LEN_W-1:0]   o_len_reg;
    logic [LEN_W-1:0]   o_leaf_reg;
    logic [CH_W-1:0]    o_byte_reg;

    logic               accept;
    logic               feed;
    logic               rd_en;
    logic               s1_move;
    logic               produce;
    logic               fin;
    logic               term_res;
    logic [1:0]         res_status;
    logic [LEN_W-1:0]   res_len;
    logic [LEN_W-1:0]   res_leaf;
    logic [CLEN_W-1:0]  comp_len;
    logic [1:0]         comp_pat;
    logic [POS_W-1:0]   nstart;
    logic [POS_W-1:0]   pos;
    logic [DEPTH_W-1:0] below_idx;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [CH_W-1:0]    mem_wdata;
    logic               stk_we;
    logic [STK_AW-1:0]  stk_waddr;
    logic [LEN_W-1:0]   stk_wdata;
    logic [CH_W-1:0]    byte_sel;

    assign s1_move   = s1_valid_reg && (!o_valid_reg || res.ready);
    assign cmd.ready = !s1_valid_reg || !o_valid_reg || res.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign feed      = accept && (cmd.mode == MODE_FEED);
    assign rd_en     = accept && (cmd.mode == MODE_READ);
    assign produce   = rd_en || term_res;
    assign below_idx = depth_next - DEPTH_W'(2);

    always_comb
    begin
        len_next    = len_reg;
        depth_next  = depth_reg;
        top_next    = top_reg;
        clen_next   = clen_reg;
        dots_next   = dots_reg;
        cnt_next    = cnt_reg;
        pbytes_next = pbytes_reg;
        nerr_next   = nerr_reg;
        perr_next   = perr_reg;
        bbad_next   = bbad_reg;
        start_next  = start_reg;
        inreq_next  = inreq_reg;
        fin         = 1'b0;
        term_res    = 1'b0;
        res_status  = ST_OK;
        comp_len    = '0;
        comp_pat    = DP_NONE;
        nstart      = '0;
        pos         = '0;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        stk_we      = 1'b0;
        stk_waddr   = '0;
        stk_wdata   = '0;

        if (feed)
        begin
            // First byte of a part: pick the part and possibly restart at the root.
            if (start_next)
            begin
                start_next = 1'b0;
                inreq_next = cmd.part;
                perr_next  = PE_NONE;
                if (cmd.part == PART_BASE)
                begin
                    len_next   = LEN_W'(1);
                    depth_next = '0;
                    cnt_next   = '0;
                    clen_next  = '0;
                    dots_next  = DP_NONE;
                    nerr_next  = 1'b0;
                    bbad_next  = (cmd.ch != CH_SLASH);
                end
                else
                begin
                    pbytes_next = '0;
                    if (cmd.ch == CH_NUL)
                    begin
                        perr_next = PE_EMPTY;
                    end
                    else if (cmd.ch == CH_SLASH)
                    begin
                        len_next   = LEN_W'(1);
                        depth_next = '0;
                        cnt_next   = '0;
                        clen_next  = '0;
                        dots_next  = DP_NONE;
                        nerr_next  = 1'b0;
                        bbad_next  = 1'b0;
                    end
                end
            end

            fin = (cmd.ch == CH_NUL) || ((cmd.ch == CH_SLASH) && !nerr_next);

            if (fin)
            begin
                comp_len  = clen_next;
                comp_pat  = dots_next;
                clen_next = '0;
                dots_next = DP_NONE;
                if ((comp_len != '0) && !nerr_next)
                begin
                    if (cnt_next <= CNT_W'(COMP_MAX))
                    begin
                        cnt_next = cnt_next + CNT_W'(1);
                    end
                    if (cnt_next > CNT_W'(COMP_MAX))
                    begin
                        nerr_next = 1'b1;
                    end
                    else if (comp_pat == DP_TWO)
                    begin
                        // A parent reference pops one component, never past the root.
                        if (depth_next != '0)
                        begin
                            len_next = (top_next > LEN_W'(1)) ? top_next - LEN_W'(1)
                                                              : LEN_W'(1);
                            if (depth_next > DEPTH_W'(1))
                            begin
                                top_next = below_reg;
                            end
                            depth_next = depth_next - DEPTH_W'(1);
                        end
                    end
                    else if (comp_pat != DP_ONE)
                    begin
                        nstart = (len_next > LEN_W'(1)) ? POS_W'(len_next) + POS_W'(1)
                                                        : POS_W'(len_next);
                        if ((len_next > LEN_W'(1)) &&
                            (POS_W'(len_next) + POS_W'(1) >= POS_W'(PATH_MAX)))
                        begin
                            nerr_next = 1'b1;
                        end
                        else if (nstart + POS_W'(comp_len) >= POS_W'(PATH_MAX))
                        begin
                            nerr_next = 1'b1;
                        end
                        else
                        begin
                            if (len_next > LEN_W'(1))
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = ADDR_W'(len_next);
                                mem_wdata = CH_SLASH;
                            end
                            if (depth_next < DEPTH_W'(COMP_MAX))
                            begin
                                stk_we     = 1'b1;
                                stk_waddr  = depth_next[STK_AW-1:0];
                                stk_wdata  = LEN_W'(nstart);
                                top_next   = LEN_W'(nstart);
                                depth_next = depth_next + DEPTH_W'(1);
                            end
                            len_next = LEN_W'(nstart + POS_W'(comp_len));
                        end
                    end
                end
            end
            else if ((cmd.ch != CH_SLASH) && !nerr_next)
            begin
                if (clen_next == CLEN_W'(NAME_MAX - 1))
                begin
                    nerr_next = 1'b1;
                end
                else
                begin
                    nstart = (len_next > LEN_W'(1)) ? POS_W'(len_next) + POS_W'(1)
                                                    : POS_W'(len_next);
                    pos = nstart + POS_W'(clen_next);
                    if (pos < POS_W'(PATH_MAX))
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = pos[ADDR_W-1:0];
                        mem_wdata = cmd.ch;
                    end
                    clen_next = clen_next + CLEN_W'(1);
                    if ((cmd.ch == CH_DOT) && ((dots_next == DP_NONE) || (dots_next == DP_ONE)))
                    begin
                        dots_next = dots_next + 2'd1;
                    end
                    else
                    begin
                        dots_next = DP_OTHER;
                    end
                end
            end

            if (cmd.ch != CH_NUL)
            begin
                if (inreq_next)
                begin
                    if (pbytes_next < PB_W'(PATH_MAX))
                    begin
                        pbytes_next = pbytes_next + PB_W'(1);
                    end
                    if ((pbytes_next >= PB_W'(PATH_MAX)) && (perr_next == PE_NONE))
                    begin
                        perr_next = PE_LONG;
                    end
                end
            end
            else
            begin
                start_next = 1'b1;
                if (inreq_next)
                begin
                    term_res = 1'b1;
                    if (perr_next == PE_EMPTY)
                    begin
                        res_status = ST_EMPTY;
                    end
                    else if (perr_next == PE_LONG)
                    begin
                        res_status = ST_TOO_LONG;
                    end
                    else if (bbad_next)
                    begin
                        res_status = ST_BASE_REL;
                    end
                    else if (nerr_next)
                    begin
                        res_status = ST_TOO_LONG;
                    end
                    if (res_status != ST_OK)
                    begin
                        len_next   = LEN_W'(1);
                        depth_next = '0;
                    end
                    bbad_next = 1'b0;
                    nerr_next = 1'b0;
                    perr_next = PE_NONE;
                    clen_next = '0;
                    dots_next = DP_NONE;
                    cnt_next  = CNT_W'(depth_next);
                end
            end
        end

        if (term_res)
        begin
            res_len  = len_next;
            res_leaf = (depth_next == '0) ? LEN_W'(1) : top_next;
        end
        else
        begin
            res_len  = len_reg;
            res_leaf = (depth_reg == '0) ? LEN_W'(1) : top_reg;
        end
    end

    assign s1_valid_next = produce || (s1_valid_reg && !s1_move);
    assign o_valid_next  = s1_move || (o_valid_reg && !res.ready);

    always_comb
    begin
        if (!s1_read_reg)
        begin
            byte_sel = CH_NUL;
        end
        else if (s1_root_reg)
        begin
            byte_sel = CH_SLASH;
        end
        else if (s1_hit_reg)
        begin
            byte_sel = rd_data_reg;
        end
        else
        begin
            byte_sel = CH_NUL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= LEN_W'(1);
            depth_reg    <= '0;
            top_reg      <= LEN_W'(1);
            clen_reg     <= '0;
            dots_reg     <= DP_NONE;
            cnt_reg      <= '0;
            pbytes_reg   <= '0;
            nerr_reg     <= 1'b0;
            perr_reg     <= PE_NONE;
            bbad_reg     <= 1'b0;
            start_reg    <= 1'b1;
            inreq_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            len_reg      <= len_next;
            depth_reg    <= depth_next;
            top_reg      <= top_next;
            clen_reg     <= clen_next;
            dots_reg     <= dots_next;
            cnt_reg      <= cnt_next;
            pbytes_reg   <= pbytes_next;
            nerr_reg     <= nerr_next;
            perr_reg     <= perr_next;
            bbad_reg     <= bbad_next;
            start_reg    <= start_next;
            inreq_reg    <= inreq_next;
            s1_valid_reg <= s1_valid_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            s1_status_reg <= rd_en ? ST_OK : res_status;
            s1_len_reg    <= res_len;
            s1_leaf_reg   <= res_leaf;
            s1_read_reg   <= rd_en;
            s1_root_reg   <= (cmd.index == '0);
            s1_hit_reg    <= (LEN_W'(cmd.index) < len_reg);
        end
        if (s1_move)
        begin
            o_status_reg <= s1_status_reg;
            o_len_reg    <= s1_len_reg;
            o_leaf_reg   <= s1_leaf_reg;
            o_byte_reg   <= byte_sel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[cmd.index];
        end
    end

    // The read address is one below the new top, so it never meets the push address.
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        below_reg <= stk_mem[below_idx[STK_AW-1:0]];
    end

    assign res.valid      = o_valid_reg;
    assign res.status     = o_status_reg;
    assign res.length     = o_len_reg;
    assign res.leaf_start = o_leaf_reg;
    assign res.byte_out   = o_byte_reg;

    `PN_ASSERT_ALWAYS(a_len_nonzero, len_reg != '0, "Path length dropped to zero.")
    `PN_ASSERT_ALWAYS(a_depth_bound, depth_reg <= DEPTH_W'(COMP_MAX), "Stack depth overran.")
    `PN_ASSERT_IMP(a_no_root_write, mem_we, mem_waddr != '0, "Store write hit the root byte.")
    `PN_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !s1_move, s1_valid_reg, "Stalled result lost.")

endmodule

@@ bench/tb_path_normalizer_core.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_path_normalizer_core
// Drives base paths, request paths and store reads into the normalizer core.
// Every accepted command item is run through a behavioral copy of the path
// builder, and every result item is compared field by field in order. Both
// channels stall at random, the receiver holds off twice for a long stretch,
// and the sender waits for an empty pipeline now and then.
// ---------------------------------------------------------------------------
module tb_path_normalizer_core;
    import pn_pkg::*;

    localparam int RANDOM_ITEMS  = 1700;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int HOLD_CYCLES   = 100;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic              mode;
        logic              part;
        logic [CH_W-1:0]   ch;
        logic [ADDR_W-1:0] index;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [LEN_W-1:0] length;
        logic [LEN_W-1:0] leaf_start;
        logic [CH_W-1:0]  byte_out;
    } res_item_t;

    typedef enum logic [1:0] {
        ENTRY_CMD,
        ENTRY_HOLD,
        ENTRY_DRAIN
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t kind;
        cmd_item_t   cmd;
    } backlog_entry_t;

    logic clk;
    logic rst_n;

    pn_cmd_if cmd_ch ();
    pn_res_if res_ch ();

    path_normalizer_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    logic [CH_W-1:0] norm_path [PATH_MAX];
    int unsigned     norm_len;
    int unsigned     comp_starts [COMP_MAX];
    int unsigned     comp_depth;
    int unsigned     comp_bytes;
    int unsigned     comp_seen;
    int unsigned     request_bytes;
    logic [1:0]      dot_state;
    logic [1:0]      req_error;
    bit              norm_overflow;
    bit              base_relative;
    bit              part_begins;
    bit              in_request_part;

    backlog_entry_t  cmd_backlog [$];
    res_item_t       path_results_due [$];
    logic [CH_W-1:0] path_bytes [$];

    int        item_total;
    int        items_accepted;
    int        mismatches;
    int        cycle_count;
    int        gap_left;
    int        stall_left;
    int        hold_left;
    int        hold_requests;
    int        holds_seen;
    bit        drv_burst;
    bit        mon_burst;
    bit        cmd_taken;
    cmd_item_t seen_cmd;
    cmd_item_t next_cmd;
    res_item_t due;

    function automatic void path_to_root();
        norm_path[0]  = CH_SLASH;
        norm_len      = 1;
        comp_depth    = 0;
        comp_seen     = 0;
        comp_bytes    = 0;
        dot_state     = DP_NONE;
        norm_overflow = 1'b0;
    endfunction

    function automatic void clear_normalizer();
        foreach (norm_path[k])
            norm_path[k] = '0;
        foreach (comp_starts[k])
            comp_starts[k] = 0;
        path_to_root();
        request_bytes   = 0;
        req_error       = PE_NONE;
        base_relative   = 1'b0;
        part_begins     = 1'b1;
        in_request_part = 1'b0;
    endfunction

    function automatic int unsigned component_origin();
        return (norm_len > 1) ? norm_len + 1 : norm_len;
    endfunction

    function automatic int unsigned leaf_position();
        if (comp_depth == 0 || comp_depth > COMP_MAX)
            return 1;
        return comp_starts[comp_depth-1];
    endfunction

    function automatic void close_component();
        int unsigned n;
        int unsigned s;
        logic [1:0]  pat;
        n          = comp_bytes;
        pat        = dot_state;
        comp_bytes = 0;
        dot_state  = DP_NONE;
        if (n == 0 || norm_overflow)
            return;
        if (comp_seen <= COMP_MAX)
            comp_seen++;
        if (comp_seen > COMP_MAX)
        begin
            norm_overflow = 1'b1;
            return;
        end
        if (pat == DP_ONE)
            return;
        if (pat == DP_TWO)
        begin
            if (comp_depth > 0 && comp_depth <= COMP_MAX)
            begin
                s = comp_starts[comp_depth-1];
                comp_depth--;
                norm_len = (s > 1) ? s - 1 : 1;
            end
            return;
        end
        if (norm_len > 1 && norm_len + 1 >= PATH_MAX)
        begin
            norm_overflow = 1'b1;
            return;
        end
        s = component_origin();
        if (s + n >= PATH_MAX)
        begin
            norm_overflow = 1'b1;
            return;
        end
        if (norm_len > 1)
            norm_path[norm_len] = CH_SLASH;
        if (comp_depth < COMP_MAX)
        begin
            comp_starts[comp_depth] = s;
            comp_depth++;
        end
        norm_len = s + n;
    endfunction

    function automatic void add_path_char(logic [CH_W-1:0] c);
        int unsigned pos;
        if (norm_overflow)
            return;
        if (c == CH_SLASH)
        begin
            close_component();
            return;
        end
        if (comp_bytes + 1 >= NAME_MAX)
        begin
            norm_overflow = 1'b1;
            return;
        end
        pos = component_origin() + comp_bytes;
        if (pos < PATH_MAX)
            norm_path[pos] = c;
        comp_bytes++;
        if (c == CH_DOT && dot_state < DP_TWO)
            dot_state++;
        else
            dot_state = DP_OTHER;
    endfunction

    function automatic void step_normalizer(cmd_item_t it);
        res_item_t  r;
        logic [1:0] st;
        if (it.mode == MODE_READ)
        begin
            r.status     = ST_OK;
            r.length     = LEN_W'(norm_len);
            r.leaf_start = LEN_W'(leaf_position());
            r.byte_out   = (it.index < norm_len) ? norm_path[it.index] : '0;
            path_results_due.push_back(r);
            return;
        end
        if (part_begins)
        begin
            part_begins     = 1'b0;
            in_request_part = it.part;
            req_error       = PE_NONE;
            if (it.part == PART_BASE)
            begin
                path_to_root();
                base_relative = (it.ch != CH_SLASH);
            end
            else
            begin
                request_bytes = 0;
                if (it.ch == CH_NUL)
                    req_error = PE_EMPTY;
                else if (it.ch == CH_SLASH)
                begin
                    path_to_root();
                    base_relative = 1'b0;
                end
            end
        end
        if (it.ch != CH_NUL)
        begin
            add_path_char(it.ch);
            if (in_request_part)
            begin
                if (request_bytes < PATH_MAX)
                    request_bytes++;
                if (request_bytes >= PATH_MAX && req_error == PE_NONE)
                    req_error = PE_LONG;
            end
            return;
        end
        close_component();
        part_begins = 1'b1;
        if (!in_request_part)
            return;
        if (req_error == PE_EMPTY)
            st = ST_EMPTY;
        else if (req_error == PE_LONG)
            st = ST_TOO_LONG;
        else if (base_relative)
            st = ST_BASE_REL;
        else if (norm_overflow)
            st = ST_TOO_LONG;
        else
            st = ST_OK;
        if (st != ST_OK)
            path_to_root();
        r.status     = st;
        r.length     = LEN_W'(norm_len);
        r.leaf_start = LEN_W'(leaf_position());
        r.byte_out   = '0;
        path_results_due.push_back(r);
        base_relative = 1'b0;
        norm_overflow = 1'b0;
        req_error     = PE_NONE;
        comp_bytes    = 0;
        dot_state     = DP_NONE;
        comp_seen     = comp_depth;
    endfunction

    function automatic void push_marker(entry_kind_t kind);
        backlog_entry_t e;
        e.kind = kind;
        e.cmd  = '0;
        cmd_backlog.push_back(e);
    endfunction

    function automatic void push_raw(logic mode, logic part, logic [CH_W-1:0] c,
                                     logic [ADDR_W-1:0] idx);
        backlog_entry_t e;
        e.kind      = ENTRY_CMD;
        e.cmd.mode  = mode;
        e.cmd.part  = part;
        e.cmd.ch    = c;
        e.cmd.index = idx;
        cmd_backlog.push_back(e);
        item_total++;
    endfunction

    function automatic void push_feed(logic part, logic [CH_W-1:0] c);
        push_raw(MODE_FEED, part, c, ADDR_W'($urandom_range(0, 255)));
    endfunction

    function automatic void push_read(logic [ADDR_W-1:0] idx);
        push_raw(MODE_READ, 1'($urandom_range(0, 1)), CH_W'($urandom_range(0, 255)), idx);
    endfunction

    function automatic logic [ADDR_W-1:0] pick_index();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return ADDR_W'($urandom_range(0, 31));
        else if (roll < 85)
            return ADDR_W'($urandom_range(0, 255));
        return ADDR_W'($urandom_range(0, 80));
    endfunction

    function automatic void add_reads(int n);
        for (int k = 0; k < n; k++)
            push_read(pick_index());
    endfunction

    function automatic void push_text(logic part, string text);
        for (int k = 0; k < text.len(); k++)
            push_feed(part, text[k]);
        push_feed(part, CH_NUL);
    endfunction

    function automatic logic [CH_W-1:0] name_char();
        string           alphabet;
        logic [CH_W-1:0] c;
        alphabet = "abcmxyz079._-~";
        if ($urandom_range(0, 7) == 0)
        begin
            c = CH_SLASH;
            while (c == CH_SLASH || c == CH_NUL)
                c = CH_W'($urandom_range(1, 255));
        end
        else
            c = alphabet[$urandom_range(0, alphabet.len() - 1)];
        return c;
    endfunction

    function automatic void add_name(int n);
        for (int k = 0; k < n; k++)
            path_bytes.push_back(name_char());
    endfunction

    function automatic void add_slashes();
        int n;
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1;
        for (int k = 0; k < n; k++)
            path_bytes.push_back(CH_SLASH);
    endfunction

    function automatic void add_component(int name_hi);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            path_bytes.push_back(CH_DOT);
        else if (pick == 1)
        begin
            path_bytes.push_back(CH_DOT);
            path_bytes.push_back(CH_DOT);
        end
        else if (pick == 2)
        begin
            path_bytes.push_back(CH_DOT);
            add_name(1);
        end
        else
            add_name($urandom_range(1, name_hi));
    endfunction

    function automatic void build_path(bit absolute, int comps, int name_hi);
        if (absolute)
            add_slashes();
        for (int k = 0; k < comps; k++)
        begin
            if (k > 0)
                add_slashes();
            add_component(name_hi);
        end
        if (comps > 0 && $urandom_range(0, 4) == 0)
            add_slashes();
    endfunction

    function automatic void send_path(logic part);
        foreach (path_bytes[k])
        begin
            if ($urandom_range(0, 32) == 0)
                push_read(pick_index());
            push_feed((k > 0 && $urandom_range(0, 9) == 0) ? ~part : part, path_bytes[k]);
        end
        push_feed((path_bytes.size() > 0 && $urandom_range(0, 9) == 0) ? ~part : part, CH_NUL);
        path_bytes.delete();
    endfunction

    function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL path_normalizer_core");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.mode  <= MODE_FEED;
            cmd_ch.part  <= PART_BASE;
            cmd_ch.ch    <= CH_NUL;
            cmd_ch.index <= '0;
        end
        else
        begin
            cmd_taken = (cmd_ch.valid === 1'b1) && (cmd_ch.ready === 1'b1);
            if (cmd_taken)
            begin
                seen_cmd.mode  = cmd_ch.mode;
                seen_cmd.part  = cmd_ch.part;
                seen_cmd.ch    = cmd_ch.ch;
                seen_cmd.index = cmd_ch.index;
                step_normalizer(seen_cmd);
                items_accepted++;
            end
            if (!cmd_ch.valid || cmd_taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    cmd_ch.valid <= 1'b0;
                end
                else if (cmd_backlog.size() == 0)
                    cmd_ch.valid <= 1'b0;
                else if (cmd_backlog[0].kind == ENTRY_HOLD)
                begin
                    hold_requests++;
                    void'(cmd_backlog.pop_front());
                    cmd_ch.valid <= 1'b0;
                end
                else if (cmd_backlog[0].kind == ENTRY_DRAIN)
                begin
                    if (path_results_due.size() == 0)
                        void'(cmd_backlog.pop_front());
                    cmd_ch.valid <= 1'b0;
                end
                else
                begin
                    next_cmd     = cmd_backlog[0].cmd;
                    void'(cmd_backlog.pop_front());
                    cmd_ch.mode  <= next_cmd.mode;
                    cmd_ch.part  <= next_cmd.part;
                    cmd_ch.ch    <= next_cmd.ch;
                    cmd_ch.index <= next_cmd.index;
                    cmd_ch.valid <= 1'b1;
                    if ($urandom_range(0, 99) < 3)
                        drv_burst = !drv_burst;
                    gap_left = drv_burst ? 0 : $urandom_range(0, 4);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if ((res_ch.valid === 1'b1) && res_ch.ready)
            begin
                if (path_results_due.size() == 0)
                begin
                    $display("%0t: result item with none expected, status %0d length %0d",
                             $time, res_ch.status, res_ch.length);
                    mismatches++;
                end
                else
                begin
                    due = path_results_due.pop_front();
                    compare_field("status", due.status, res_ch.status);
                    compare_field("length", due.length, res_ch.length);
                    compare_field("leaf_start", due.leaf_start, res_ch.leaf_start);
                    compare_field("byte_out", due.byte_out, res_ch.byte_out);
                end
                if ($urandom_range(0, 99) < 3)
                    mon_burst = !mon_burst;
                stall_left = mon_burst ? 0 : $urandom_range(0, 4);
            end
            if (holds_seen != hold_requests)
            begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
                res_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        int   pick;
        int   n;
        int   random_end;
        int   next_hold;
        int   next_drain;
        int   next_long;
        logic part;

        rst_n        = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.mode  = MODE_FEED;
        cmd_ch.part  = PART_BASE;
        cmd_ch.ch    = CH_NUL;
        cmd_ch.index = '0;
        res_ch.ready = 1'b0;
        clear_normalizer();

        push_feed(PART_REQ, CH_NUL);
        push_read('0);
        push_read('1);
        push_text(PART_BASE, "a");
        push_text(PART_REQ, "b");
        push_text(PART_BASE, "");
        push_text(PART_REQ, "x");
        push_text(PART_REQ, "/./a//b/..");
        push_read(ADDR_W'(1));
        push_read(ADDR_W'(2));

        random_end = item_total + RANDOM_ITEMS;
        next_hold  = item_total + 500;
        next_drain = item_total + 250;
        next_long  = item_total + 300;
        while (item_total < random_end)
        begin
            if (item_total >= next_hold)
            begin
                push_marker(ENTRY_HOLD);
                add_reads(24);
                next_hold += 700;
            end
            if (item_total >= next_drain || $urandom_range(0, 49) == 0)
            begin
                push_marker(ENTRY_DRAIN);
                if (item_total >= next_drain)
                    next_drain += 500;
            end
            if (item_total >= next_long)
            begin
                n = $urandom_range(PATH_MAX - 2, PATH_MAX + 1);
                path_bytes.push_back(CH_SLASH);
                while (path_bytes.size() < n)
                begin
                    add_name($urandom_range(40, 62));
                    path_bytes.push_back(CH_SLASH);
                    path_bytes.push_back(CH_DOT);
                    path_bytes.push_back(CH_DOT);
                    path_bytes.push_back(CH_SLASH);
                end
                while (path_bytes.size() > n)
                    void'(path_bytes.pop_back());
                send_path(PART_REQ);
                add_reads(2);
                next_long += 800;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                build_path($urandom_range(0, 9) != 0, $urandom_range(0, 5), 8);
                send_path(PART_BASE);
                build_path($urandom_range(0, 2) == 0, $urandom_range(0, 5), 8);
                send_path(PART_REQ);
                add_reads($urandom_range(1, 4));
            end
            else if (pick < 55)
            begin
                build_path($urandom_range(0, 3) == 0, $urandom_range(1, 6), 8);
                send_path(PART_REQ);
                add_reads($urandom_range(0, 3));
            end
            else if (pick < 65)
                add_reads($urandom_range(1, 6));
            else if (pick < 72)
            begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                    push_raw(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             ($urandom_range(0, 3) == 0) ? CH_NUL : CH_W'($urandom_range(0, 255)),
                             ADDR_W'($urandom_range(0, 255)));
            end
            else if (pick < 75)
            begin
                push_feed(PART_REQ, CH_NUL);
                add_reads(1);
            end
            else if (pick < 82)
            begin
                part = 1'($urandom_range(0, 1));
                path_bytes.push_back(CH_SLASH);
                add_name($urandom_range(NAME_MAX - 3, NAME_MAX + 1));
                if ($urandom_range(0, 1) == 0)
                begin
                    path_bytes.push_back(CH_SLASH);
                    add_name(2);
                end
                send_path(part);
                if (part == PART_BASE)
                begin
                    build_path(1'b0, 2, 4);
                    send_path(PART_REQ);
                end
                add_reads(2);
            end
            else if (pick < 89)
            begin
                n = $urandom_range(COMP_MAX - 4, COMP_MAX + 4);
                path_bytes.push_back(CH_SLASH);
                for (int k = 0; k < n; k++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        path_bytes.push_back(CH_DOT);
                    else
                        add_name(1);
                    path_bytes.push_back(CH_SLASH);
                end
                send_path(PART_REQ);
                add_reads(2);
            end
            else if (pick < 98)
            begin
                build_path(1'b0, $urandom_range(3, 8), 8);
                send_path(PART_REQ);
                add_reads($urandom_range(1, 3));
            end
            else
            begin
                n = $urandom_range(5, 9);
                path_bytes.push_back(CH_SLASH);
                for (int k = 0; k < n; k++)
                begin
                    add_name($urandom_range(25, 45));
                    path_bytes.push_back(CH_SLASH);
                end
                send_path(PART_REQ);
                add_reads(3);
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        while (items_accepted < item_total)
            @(posedge clk);
        while (path_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS path_normalizer_core");
        else
            $display("FAIL path_normalizer_core");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/pn_pkg.sv
rtl/pn_ifs.sv
rtl/path_normalizer_core.sv
bench/tb_path_normalizer_core.sv
